### rtl/tbfc_pkg.sv
// Shared types and constants for the template bit field codec.
`timescale 1ns / 1ps
`default_nettype none
package tbfc_pkg;

  localparam int TEMPLATE_DEPTH_DEF = 32;
  localparam int BUFFER_BYTES_DEF   = 256;
  localparam int BYTE_BITS          = 8;
  localparam int VALUE_W            = 64;
  localparam int MAX_SPAN_BYTES     = 8;
  localparam int BASE_W             = 11;
  localparam int COUNT_W            = 6;
  localparam int CFG_DATA_W         = 11;

  typedef enum logic [2:0] {
    ACT_TMPL_WR = 3'd0,
    ACT_BYTE_WR = 3'd1,
    ACT_BYTE_RD = 3'd2,
    ACT_GET     = 3'd3,
    ACT_SET     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_GEOMETRY = 2'd2
  } status_e;

  typedef enum logic {
    CFG_BASE_OFFSET = 1'b0,
    CFG_TMPL_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_BYTE,
    RES_FIELD,
    RES_UNKNOWN,
    RES_GEOM
  } res_e;

  typedef enum logic [1:0] {
    RA_INDEX,
    RA_START,
    RA_NEXT
  } raddr_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_BYTE_RD,
    S_WALK,
    S_GEOM,
    S_FETCH,
    S_MERGE,
    S_STORE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load_in;
    logic       tmpl_wr;
    logic       buf_wr_idx;
    raddr_sel_e raddr_sel;
    logic       walk_start;
    logic       walk_step;
    logic       walk_hit;
    logic       byte_capture;
    logic       geom_load;
    logic       fetch_step;
    logic       merge;
    logic       store_step;
    logic       res_load;
    res_e       res_kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e act;
    logic    tmpl_idx_ok;
    logic    buf_idx_ok;
    logic    cnt_zero;
    logic    hit;
    logic    last_entry;
    logic    geom_bad;
    logic    last_byte;
    logic    out_free;
  } stat_t;

endpackage
`default_nettype wire

### rtl/template_bit_field_codec_unit.sv
// Top level of the template driven big endian bit field codec.
`timescale 1ns / 1ps
`default_nettype none
// Holds a field template (id and bit length per slot) and a byte buffer whose
// bits are numbered MSB first. Beat actions: write template slot, write
// buffer byte, read buffer byte, get field, set field. Get/set walk the
// template from slot 0 one entry per cycle (registered template read),
// summing lengths onto base_bit_offset until the id matches, check geometry,
// then move the field's bytes through the buffer's one read and one write
// port one byte per cycle. One beat is in flight at a time. The walk visits
// up to 32 template entries and a field touches up to 8 buffer bytes.
// A finished result sits in the output register, and the block returns to
// accept the next beat once that result has a place there. Configuration
// (register 0 base_bit_offset, register 1 template_count) must be written
// only while idle; the block itself does not enforce this. Template and
// buffer contents are undefined until written.
module template_bit_field_codec_unit #(
  parameter int TEMPLATE_DEPTH = tbfc_pkg::TEMPLATE_DEPTH_DEF,
  parameter int BUFFER_BYTES   = tbfc_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [tbfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [2:0]                      action_i,
  input  wire logic [7:0]                      index_i,
  input  wire logic [7:0]                      field_id_i,
  input  wire logic [6:0]                      field_len_i,
  input  wire logic [tbfc_pkg::VALUE_W-1:0]    value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [tbfc_pkg::VALUE_W-1:0]         value_out_o,
  output logic [1:0]                           status_o
);
  import tbfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  tbfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, walk arithmetic, byte shifter, result register
  tbfc_dp #(
    .TEMPLATE_DEPTH (TEMPLATE_DEPTH),
    .BUFFER_BYTES   (BUFFER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .index_i     (index_i),
    .field_id_i  (field_id_i),
    .field_len_i (field_len_i),
    .value_i     (value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .value_out_o (value_out_o),
    .status_o    (status_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

### rtl/tbfc_ctrl.sv
// Sequencer for the template bit field codec.
`timescale 1ns / 1ps
`default_nettype none
module tbfc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  tbfc_pkg::stat_t    stat_i,
  output tbfc_pkg::cmd_t     cmd_o
);
  import tbfc_pkg::*;

  state_e state_q, state_d;
  res_e   kind_q, kind_d;
  logic   done_q, done_d;   // result waiting for the output register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= RES_ZERO;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    done_d     = done_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.raddr_sel = RA_NEXT;
    cmd_o.res_kind  = kind_q;

    unique case (state_q)
      S_IDLE: begin
        if (done_q) begin
          if (stat_i.out_free) begin
            cmd_o.res_load = 1'b1;
            done_d         = 1'b0;
          end
        end else begin
          in_ready_o    = 1'b1;
          cmd_o.load_in = in_valid_i;
          if (in_valid_i) state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        kind_d  = RES_ZERO;
        case (stat_i.act)
          ACT_TMPL_WR: cmd_o.tmpl_wr = stat_i.tmpl_idx_ok;
          ACT_BYTE_WR: cmd_o.buf_wr_idx = stat_i.buf_idx_ok;
          ACT_BYTE_RD: begin
            cmd_o.raddr_sel = RA_INDEX;
            if (stat_i.buf_idx_ok) begin
              done_d  = 1'b0;
              state_d = S_BYTE_RD;
            end else begin
              kind_d = RES_GEOM;
            end
          end
          ACT_GET, ACT_SET: begin
            cmd_o.walk_start = 1'b1;
            if (stat_i.cnt_zero) begin
              kind_d = RES_UNKNOWN;
            end else begin
              done_d  = 1'b0;
              state_d = S_WALK;
            end
          end
          default: ;
        endcase
      end
      S_BYTE_RD: begin
        cmd_o.byte_capture = 1'b1;
        kind_d  = RES_BYTE;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        if (stat_i.hit) begin
          cmd_o.walk_hit = 1'b1;
          state_d        = S_GEOM;
        end else if (stat_i.last_entry) begin
          kind_d  = RES_UNKNOWN;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_GEOM: begin
        cmd_o.raddr_sel = RA_START;
        if (stat_i.geom_bad) begin
          kind_d  = RES_GEOM;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.geom_load = 1'b1;
          state_d         = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch_step = 1'b1;
        if (stat_i.last_byte) begin
          if (stat_i.act == ACT_GET) begin
            kind_d  = RES_FIELD;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_STORE;
      end
      S_STORE: begin
        cmd_o.store_step = 1'b1;
        if (stat_i.last_byte) begin
          kind_d  = RES_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/tbfc_dp.sv
// Datapath: config registers, template and byte memories, field shifter.
`timescale 1ns / 1ps
`default_nettype none
module tbfc_dp #(
  parameter int TEMPLATE_DEPTH = tbfc_pkg::TEMPLATE_DEPTH_DEF,
  parameter int BUFFER_BYTES   = tbfc_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tbfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [2:0]                    action_i,
  input  wire logic [7:0]                    index_i,
  input  wire logic [7:0]                    field_id_i,
  input  wire logic [6:0]                    field_len_i,
  input  wire logic [tbfc_pkg::VALUE_W-1:0]  value_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [tbfc_pkg::VALUE_W-1:0]       value_out_o,
  output logic [1:0]                         status_o,
  input  tbfc_pkg::cmd_t                     cmd_i,
  output tbfc_pkg::stat_t                    stat_o
);
  import tbfc_pkg::*;

  localparam int TI_W   = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int OFF_W  = $clog2(2048 + TEMPLATE_DEPTH * 128);

  // config
  logic [BASE_W-1:0]  base_q;
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_OFFSET: base_q  <= cfg_wdata_i[BASE_W-1:0];
        CFG_TMPL_COUNT:  count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // latched beat
  logic [2:0]         act_q;
  logic [7:0]         idx_q;
  logic [7:0]         fid_q;
  logic [6:0]         flen_q;
  logic [VALUE_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q  <= action_i;
      idx_q  <= index_i;
      fid_q  <= field_id_i;
      flen_q <= field_len_i;
      val_q  <= value_i;
    end
  end

  // template memory
  logic [7:0] tmpl_id_mem  [TEMPLATE_DEPTH];
  logic [6:0] tmpl_len_mem [TEMPLATE_DEPTH];
  logic [7:0] tmpl_id_rd_q;
  logic [6:0] tmpl_len_rd_q;
  logic [TI_W-1:0] entry_q;
  logic [TI_W-1:0] tmpl_raddr;

  assign tmpl_raddr = cmd_i.walk_start ? '0 : TI_W'(entry_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tmpl_wr) begin
      tmpl_id_mem[TI_W'(idx_q)]  <= fid_q;
      tmpl_len_mem[TI_W'(idx_q)] <= flen_q;
    end
    tmpl_id_rd_q  <= tmpl_id_mem[tmpl_raddr];
    tmpl_len_rd_q <= tmpl_len_mem[tmpl_raddr];
  end

  // walk
  logic [OFF_W-1:0] off_q;
  logic [6:0]       len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      entry_q <= '0;
      off_q   <= OFF_W'(base_q);
    end else if (cmd_i.walk_step) begin
      entry_q <= TI_W'(entry_q + 1'b1);
      off_q   <= off_q + OFF_W'(tmpl_len_rd_q);
    end
    if (cmd_i.walk_hit) len_q <= tmpl_len_rd_q;
  end

  // geometry
  logic [OFF_W-1:0] end_bit;
  logic [OFF_W-1:0] sb_full, eb_full;
  logic             geom_bad;

  assign end_bit  = off_q + OFF_W'(len_q) - 1'b1;
  assign sb_full  = off_q >> 3;
  assign eb_full  = end_bit >> 3;
  assign geom_bad = (len_q == '0) || (len_q > 7'(VALUE_W)) ||
                    ((eb_full - sb_full) > OFF_W'(MAX_SPAN_BYTES - 1)) ||
                    (32'(eb_full) >= BUFFER_BYTES);

  logic [ADDR_W-1:0] sb_q;
  logic [3:0]        nb_q;
  logic [3:0]        k_q;
  logic [2:0]        pad_q;
  logic [VALUE_W-1:0] acc_q;

  // byte memory
  logic [7:0]        byte_mem [BUFFER_BYTES];
  logic [7:0]        byte_rd_q;
  logic [ADDR_W-1:0] byte_raddr;
  logic [ADDR_W-1:0] byte_waddr;
  logic              byte_we;
  logic [7:0]        byte_wdata;

  always_comb begin
    case (cmd_i.raddr_sel)
      RA_INDEX: byte_raddr = ADDR_W'(idx_q);
      RA_START: byte_raddr = sb_full[ADDR_W-1:0];
      default:  byte_raddr = sb_q + ADDR_W'(k_q) + 1'b1;
    endcase
  end

  assign byte_we    = cmd_i.buf_wr_idx || cmd_i.store_step;
  assign byte_waddr = cmd_i.store_step ? (sb_q + ADDR_W'(k_q)) : ADDR_W'(idx_q);
  assign byte_wdata = cmd_i.store_step ? acc_q[VALUE_W-1 -: 8] : val_q[7:0];

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
    byte_rd_q <= byte_mem[byte_raddr];
  end

  // field shifter
  logic [VALUE_W-1:0] mask;
  logic [VALUE_W-1:0] merged;
  logic [5:0]         align_sh;

  assign mask     = ~({VALUE_W{1'b1}} << len_q);
  assign merged   = (acc_q & ~(mask << pad_q)) | ((val_q & mask) << pad_q);
  assign align_sh = {3'(4'd8 - nb_q), 3'b000};

  always_ff @(posedge clk_i) begin
    if (cmd_i.geom_load) begin
      sb_q  <= sb_full[ADDR_W-1:0];
      nb_q  <= 4'(eb_full - sb_full) + 4'd1;
      pad_q <= ~end_bit[2:0];
      k_q   <= '0;
      acc_q <= '0;
    end else if (cmd_i.fetch_step) begin
      acc_q <= {acc_q[VALUE_W-9:0], byte_rd_q};
      k_q   <= k_q + 4'd1;
    end else if (cmd_i.merge) begin
      acc_q <= merged << align_sh;
      k_q   <= '0;
    end else if (cmd_i.store_step) begin
      acc_q <= acc_q << 8;
      k_q   <= k_q + 4'd1;
    end else if (cmd_i.byte_capture) begin
      acc_q <= VALUE_W'(byte_rd_q);
    end
  end

  // output register
  logic               out_valid_q;
  logic [VALUE_W-1:0] value_out_q;
  logic [1:0]         status_q;
  logic [VALUE_W-1:0] res_value;
  status_e            res_status;

  always_comb begin
    res_value  = '0;
    res_status = ST_OK;
    case (cmd_i.res_kind)
      RES_BYTE:    res_value = acc_q;
      RES_FIELD:   res_value = (acc_q >> pad_q) & mask;
      RES_UNKNOWN: begin
        res_value  = '1;
        res_status = ST_UNKNOWN;
      end
      RES_GEOM: begin
        res_value  = '1;
        res_status = ST_GEOMETRY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      value_out_q <= res_value;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;

  // status to controller
  always_comb begin
    stat_o             = '0;
    stat_o.act         = action_e'(act_q);
    stat_o.tmpl_idx_ok = 32'(idx_q) < TEMPLATE_DEPTH;
    stat_o.buf_idx_ok  = 32'(idx_q) < BUFFER_BYTES;
    stat_o.cnt_zero    = (count_q == '0);
    stat_o.hit         = (tmpl_id_rd_q == fid_q);
    stat_o.last_entry  = (32'(entry_q) + 1 >= 32'(count_q)) ||
                         (32'(entry_q) + 1 >= TEMPLATE_DEPTH);
    stat_o.geom_bad    = geom_bad;
    stat_o.last_byte   = (k_q + 4'd1) == nb_q;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

### rtl/tbfc_checker.sv
// Port level checks for the codec, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tbfc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] value_out_o,
  input wire logic [1:0]  status_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_out_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // every error answers all ones
  a_err_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> value_out_o == {64{1'b1}})
    else $error("error result not all ones");

  // one beat at a time
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

endmodule

bind template_bit_field_codec_unit tbfc_checker u_tbfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_out_o (value_out_o),
  .status_o    (status_o)
);
`default_nettype wire

### tb/template_bit_field_codec_unit_tb.sv
// Self-checking testbench for the template bit field codec unit.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the codec's template, buffer and registers, works out the result
// each accepted beat must produce, and matches results in order.
class field_codec_scoreboard;
  bit [10:0]  base_offset;
  bit [5:0]   slot_count;
  bit [7:0]   slot_id   [32];
  bit [6:0]   slot_len  [32];
  bit [7:0]   buf_bytes [256];
  bit [63:0]  want_value_q [$];
  bit [1:0]   want_status_q [$];
  int         mismatches;
  int         unexpected;

  function void set_reg(bit idx, bit [10:0] data);
    if (idx == tbfc_pkg::CFG_BASE_OFFSET) base_offset = data;
    else slot_count = data[5:0];
  endfunction

  // Walk the template for a get or set; returns the status and the
  // field position when the lookup succeeds.
  function bit [1:0] find_field(bit [7:0] id, output int first, output int nbytes,
                                output int pad, output int flen);
    int n, off, i, last_bit;
    n = (slot_count < 32) ? slot_count : 32;
    off = base_offset;
    first = 0; nbytes = 0; pad = 0; flen = 0;
    for (i = 0; i < n; i++) begin
      if (slot_id[i] == id) break;
      off += slot_len[i];
    end
    if (i == n) return tbfc_pkg::ST_UNKNOWN;
    flen = slot_len[i];
    if (flen == 0 || flen > 64) return tbfc_pkg::ST_GEOMETRY;
    last_bit = off + flen - 1;
    if (last_bit / 8 - off / 8 + 1 > 8 || last_bit / 8 >= 256)
      return tbfc_pkg::ST_GEOMETRY;
    first = off / 8;
    nbytes = last_bit / 8 - off / 8 + 1;
    pad = 7 - last_bit % 8;
    return tbfc_pkg::ST_OK;
  endfunction

  function void note_beat(bit [2:0] act, bit [7:0] idx, bit [7:0] id,
                          bit [6:0] flen_in, bit [63:0] val);
    bit [63:0] vout, acc, mask;
    bit [1:0]  st;
    int first, nbytes, pad, flen, k;
    vout = '0;
    st = tbfc_pkg::ST_OK;
    case (act)
      tbfc_pkg::ACT_TMPL_WR: begin
        if (idx < 32) begin
          slot_id[idx] = id;
          slot_len[idx] = flen_in;
        end
      end
      tbfc_pkg::ACT_BYTE_WR: buf_bytes[idx] = val[7:0];
      tbfc_pkg::ACT_BYTE_RD: vout = buf_bytes[idx];
      tbfc_pkg::ACT_GET, tbfc_pkg::ACT_SET: begin
        st = find_field(id, first, nbytes, pad, flen);
        if (st != tbfc_pkg::ST_OK) begin
          vout = '1;
        end else begin
          acc = '0;
          mask = (flen >= 64) ? '1 : ((64'd1 << flen) - 64'd1);
          for (k = 0; k < nbytes; k++) acc = (acc << 8) | buf_bytes[first + k];
          if (act == tbfc_pkg::ACT_GET) begin
            vout = (acc >> pad) & mask;
          end else begin
            acc = (acc & ~(mask << pad)) | ((val & mask) << pad);
            for (k = nbytes - 1; k >= 0; k--) begin
              buf_bytes[first + k] = acc[7:0];
              acc = acc >> 8;
            end
          end
        end
      end
      default: ;
    endcase
    want_value_q.push_back(vout);
    want_status_q.push_back(st);
  endfunction

  function void check_result(bit [63:0] vout, bit [1:0] st);
    bit [63:0] wv;
    bit [1:0]  ws;
    if (want_value_q.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= 10)
        $display("Result with nothing pending: value %h status %0d", vout, st);
      return;
    end
    wv = want_value_q.pop_front();
    ws = want_status_q.pop_front();
    if (wv !== vout || ws !== st) begin
      mismatches++;
      if (mismatches + unexpected <= 10)
        $display("Mismatch: value exp %h got %h, status exp %0d got %0d",
                 wv, vout, ws, st);
    end
  endfunction

  function bit busy();
    return want_value_q.size() != 0;
  endfunction

  function bit failed();
    return (mismatches + unexpected) != 0;
  endfunction
endclass

module template_bit_field_codec_unit_tb;
  import tbfc_pkg::*;

  // Actions 5..7 are undefined and must be no-ops returning zero.
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;
  // Cycles with no beat accepted on either side before we give up.
  localparam int STALL_LIMIT = 5000;
  // Drain time after the last result.
  localparam int DRAIN_CYCLES = 100;
  // Random beats per register setting.
  localparam int PHASE_BEATS = 32;
  localparam logic [CFG_DATA_W-1:0] PHASE_BASES [6] = '{11'd0, 11'd3, 11'd2047,
                                                        11'd1000, 11'd0, 11'd517};
  localparam logic [CFG_DATA_W-1:0] PHASE_COUNTS [6] = '{11'd32, 11'd32, 11'h7FF,
                                                         11'd20, 11'd0, 11'd5};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            action;
  logic [7:0]            index;
  logic [7:0]            field_id;
  logic [6:0]            field_len;
  logic [VALUE_W-1:0]    value;
  logic                  out_valid;
  logic                  out_ready;
  logic [VALUE_W-1:0]    value_out;
  logic [1:0]            status;

  // Set during the no-idle stretch: both sides run flat out.
  bit calm;
  int quiet_cycles;

  field_codec_scoreboard codec_sb = new();

  always #1 clk = ~clk;

  template_bit_field_codec_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .index_i     (index),
    .field_id_i  (field_id),
    .field_len_i (field_len),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .value_out_o (value_out),
    .status_o    (status)
  );

  // Result side: random backpressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // Sample both handshakes on the rising edge; watchdog on stuck traffic.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) codec_sb.check_result(value_out, status);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drive one beat; called and returns at a falling edge. Valid stays high
  // across back-to-back beats, so it is only lowered for an idle gap.
  task automatic send_beat(logic [2:0] act, logic [7:0] idx, logic [7:0] id,
                           logic [6:0] flen, logic [63:0] val);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    index = idx;
    field_id = id;
    field_len = flen;
    value = val;
    do @(posedge clk); while (!in_ready);
    codec_sb.note_beat(act, idx, id, flen, val);
    @(negedge clk);
  endtask

  // Idle the sender, then let everything drain.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (codec_sb.busy()) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Registers only change with the block idle.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    codec_sb.set_reg(idx, data);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random beat, biased toward get/set on ids the template usually holds.
  task automatic random_beat();
    int pick;
    logic [6:0] flen;
    logic [7:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    if (pick < 10) begin
      case ($urandom_range(9))
        0: flen = 7'd0;
        1: flen = 7'($urandom_range(65, 127));
        2: flen = 7'($urandom_range(17, 64));
        default: flen = 7'($urandom_range(1, 16));
      endcase
      send_beat(ACT_TMPL_WR, 8'($urandom_range(0, 40)), id, flen, rand64());
    end else if (pick < 20) begin
      send_beat(ACT_BYTE_WR, 8'($urandom), 8'($urandom), 7'($urandom), rand64());
    end else if (pick < 30) begin
      send_beat(ACT_BYTE_RD, 8'($urandom), 8'($urandom), 7'($urandom), rand64());
    end else if (pick < 65) begin
      send_beat(ACT_GET, 8'($urandom), id, 7'($urandom), rand64());
    end else if (pick < 95) begin
      send_beat(ACT_SET, 8'($urandom), id, 7'($urandom), rand64());
    end else begin
      send_beat(3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI)), 8'($urandom),
                8'($urandom), 7'($urandom), rand64());
    end
  endtask

  initial begin
    int i, ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_BASE_OFFSET;
    cfg_wdata = '0;
    in_valid = 1'b0;
    action = ACT_TMPL_WR;
    index = '0;
    field_id = '0;
    field_len = '0;
    value = '0;
    out_ready = 1'b0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Fill the whole buffer and template first, so that no walk or field
    // fetch ever touches storage that was never written.
    for (i = 0; i < 256; i++) send_beat(ACT_BYTE_WR, 8'(i), 8'd0, 7'd0, rand64());
    for (i = 0; i < 32; i++) send_beat(ACT_TMPL_WR, 8'(i), 8'(i), 7'd8, '0);
    write_reg(CFG_BASE_OFFSET, 11'd0);
    write_reg(CFG_TMPL_COUNT, 11'd32);

    // Directed corners.
    send_beat(ACT_GET, 8'd0, 8'd3, 7'd0, '0);
    send_beat(ACT_SET, 8'd0, 8'd3, 7'd0, '1);
    send_beat(ACT_GET, 8'd0, 8'd3, 7'd0, '0);
    send_beat(ACT_BYTE_RD, 8'd3, 8'd0, 7'd0, '0);
    send_beat(ACT_BYTE_WR, 8'hFF, 8'hFF, 7'h7F, '1);
    send_beat(ACT_BYTE_RD, 8'hFF, 8'hFF, 7'h7F, '1);
    send_beat(ACT_GET, 8'd0, 8'hEE, 7'd0, '0);           // unknown id
    for (i = ACT_RSVD_LO; i <= ACT_RSVD_HI; i++)
      send_beat(3'(i), 8'hFF, 8'hFF, 7'h7F, '1);
    send_beat(ACT_TMPL_WR, 8'hFF, 8'd1, 7'd9, '0);       // slot out of range
    send_beat(ACT_TMPL_WR, 8'd0, 8'hFF, 7'd64, '0);      // full 64-bit field
    send_beat(ACT_GET, 8'd0, 8'hFF, 7'd0, '0);
    send_beat(ACT_SET, 8'd0, 8'hFF, 7'd0, 64'h8000_0000_0000_0001);
    send_beat(ACT_GET, 8'd0, 8'hFF, 7'd0, '0);
    send_beat(ACT_TMPL_WR, 8'd1, 8'h55, 7'd0, '0);       // zero length
    send_beat(ACT_GET, 8'd0, 8'h55, 7'd0, '0);
    send_beat(ACT_TMPL_WR, 8'd2, 8'h7E, 7'h7F, '0);      // length past 64
    send_beat(ACT_SET, 8'd0, 8'h7E, 7'd0, '1);
    send_beat(ACT_TMPL_WR, 8'd5, 8'd4, 7'd1, '0);        // duplicate id 4
    send_beat(ACT_SET, 8'd0, 8'd4, 7'd0, '1);
    send_beat(ACT_GET, 8'd0, 8'd4, 7'd0, '0);
    send_beat(ACT_TMPL_WR, 8'd31, 8'd4, 7'd1, '0);

    // Sender holds off until every result is back.
    wait_idle();

    // Random phases across register settings, extremes included.
    for (ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BASE_OFFSET, PHASE_BASES[ph]);
      write_reg(CFG_TMPL_COUNT, PHASE_COUNTS[ph]);
      for (i = 0; i < PHASE_BEATS; i++) begin
        calm = (ph == 1 && i >= 4 && i < 28);
        random_beat();
      end
      calm = 1'b0;
    end

    wait_idle();
    if (codec_sb.failed()) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end
endmodule

`default_nettype wire
